>>> hw/rtl/nrstp_pkg.sv
// nrstp_pkg: shared types, event and status codes and parameter defaults
// for the nested range self-time profiler; no dependencies
`default_nettype none

package nrstp_pkg;

	// parameter defaults
	localparam int STACK_DEPTH_DEF  = 16;
	localparam int LAYER_COUNT_DEF  = 12;
	localparam int TIME_BITS_DEF    = 48;
	localparam int SESSION_BITS_DEF = 16;

	// fixed field widths
	localparam int FUNC_W   = 2;
	localparam int LAYER_W  = 4;
	localparam int TS_W     = 48;
	localparam int DEPTH_W  = 5;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 4;

	// event kinds
	localparam logic [FUNC_W-1:0] FN_OPEN  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_CLOSE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_START = 2'd2;
	localparam logic [FUNC_W-1:0] FN_STOP  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_OK         = 4'd0;
	localparam logic [STATUS_W-1:0] STS_IGNORED    = 4'd1;
	localparam logic [STATUS_W-1:0] STS_MISMATCH   = 4'd2;
	localparam logic [STATUS_W-1:0] STS_ACTIVE     = 4'd3;
	localparam logic [STATUS_W-1:0] STS_EXHAUSTED  = 4'd4;
	localparam logic [STATUS_W-1:0] STS_NOT_ACTIVE = 4'd5;
	localparam logic [STATUS_W-1:0] STS_UNCLOSED   = 4'd6;
	localparam logic [STATUS_W-1:0] STS_REC_FAIL   = 4'd7;
	localparam logic [STATUS_W-1:0] STS_BAD_LAYER  = 4'd8;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW   = 4'd9;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [LAYER_W-1:0] layer;
		logic [TS_W-1:0]    timestamp;
		logic [DEPTH_W-1:0] expected_depth;
		logic [TAG_W-1:0]   session_tag;
		logic               scope_armed;
	} evt_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                sample_valid;
		logic [LAYER_W-1:0]  out_layer;
		logic [DEPTH_W-1:0]  out_depth;
		logic [TAG_W-1:0]    out_session;
		logic [TS_W-1:0]     inclusive_ns;
		logic [TS_W-1:0]     self_ns;
	} res_t;

endpackage

`default_nettype wire

>>> hw/rtl/nested_range_self_time_profiler_unit.sv
// nested_range_self_time_profiler_unit: top level, output register and frame ram
// depends on nrstp_pkg, nrstp_ctrl and nrstp_ram
//
//   channel | direction | handshake            | payload
//   evt     | in        | evt_valid/evt_ready  | evt_t (func, layer, timestamp, ...)
//   res     | out       | res_valid/res_ready  | res_t (status, sample, times, ...)
//
// one transaction on evt gives exactly one transaction on res, in order
// open, start, stop and closes refused before the frame read go from accept straight
// to the output step; a close refused on its layer reads the top frame first
// an accepted close reads the top frame, computes self time and, if a parent frame is
// left, updates its child time by read-modify-write over the single ram read port
// a full output register holds the sequencer in its final step until res_ready
// reset clears the stack count, session state and failure flag; frames need none
`default_nettype none

module nested_range_self_time_profiler_unit
	import nrstp_pkg::*;
#(
	parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
	parameter int LAYER_COUNT  = LAYER_COUNT_DEF,
	parameter int TIME_BITS    = TIME_BITS_DEF,
	parameter int SESSION_BITS = SESSION_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic evt_valid,
	output      logic evt_ready,
	input  wire evt_t evt,
	output      logic res_valid,
	input  wire logic res_ready,
	output      res_t res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int FW = LAYER_W + 2 * TIME_BITS;

	// sequencer side of the output register
	logic done_valid;
	res_t done;
	logic take;

	// frame ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [FW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [FW-1:0] ram_rdata;

	logic res_valid_q;
	res_t res_q;

	// the register takes a new result when it is empty or being drained
	assign take      = done_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (take) begin
				res_valid_q <= 1'b1;
				res_q       <= done;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// frames: {layer, start time, accumulated child time}
	nrstp_ram #(
		.WIDTH(FW),
		.DEPTH(STACK_DEPTH)
	) u_frames (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// event decode, session registers and frame read-modify-write
	nrstp_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.LAYER_COUNT (LAYER_COUNT),
		.TIME_BITS   (TIME_BITS),
		.SESSION_BITS(SESSION_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.done_valid(done_valid),
		.done      (done),
		.take      (take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule

`default_nettype wire

>>> hw/rtl/nrstp_ram.sv
// nrstp_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module nrstp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/nrstp_ctrl.sv
// nrstp_ctrl: event sequencer, session/stack registers and frame ram access
// depends on nrstp_pkg; drives an nrstp_ram holding {layer, start, child}
`default_nettype none

module nrstp_ctrl
	import nrstp_pkg::*;
#(
	parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
	parameter int LAYER_COUNT  = LAYER_COUNT_DEF,
	parameter int TIME_BITS    = TIME_BITS_DEF,
	parameter int SESSION_BITS = SESSION_BITS_DEF,
	localparam int AW = $clog2(STACK_DEPTH),
	localparam int FW = LAYER_W + 2 * TIME_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          evt_valid,
	output      logic          evt_ready,
	input  wire evt_t          evt,
	output      logic          done_valid,
	output      res_t          done,
	input  wire logic          take,
	output      logic          ram_we,
	output      logic [AW-1:0] ram_waddr,
	output      logic [FW-1:0] ram_wdata,
	output      logic [AW-1:0] ram_raddr,
	input  wire logic [FW-1:0] ram_rdata
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TOP  = 3'd1;
	localparam logic [2:0] S_SELF = 3'd2;
	localparam logic [2:0] S_PAR  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	logic                    active_q;
	logic                    failed_q;
	logic [SESSION_BITS-1:0] sess_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [LAYER_W-1:0]      layer_q;
	logic [TIME_BITS-1:0]    incl_q;
	logic [TIME_BITS-1:0]    child_q;
	res_t                    res_q;

	logic                 accept;
	logic [TIME_BITS-1:0] now;
	logic                 layer_ok;
	logic                 depth_ok;
	logic                 tag_ok;
	logic                 full;
	logic                 sess_max;
	logic                 push;
	logic [LAYER_W-1:0]   rd_layer;
	logic [TIME_BITS-1:0] rd_start;
	logic [TIME_BITS-1:0] rd_child;
	logic [TIME_BITS:0]   incl_diff;
	logic [TIME_BITS:0]   self_diff;
	logic [TIME_BITS:0]   par_sum;
	logic [TIME_BITS-1:0] par_child;

	// register updates decided at accept
	res_t                    acc_res;
	logic [2:0]              acc_state;
	logic [CNT_W-1:0]        acc_count;
	logic                    acc_active;
	logic                    acc_failed;
	logic [SESSION_BITS-1:0] acc_sess;

	assign evt_ready  = (state_q == S_IDLE);
	assign accept     = evt_valid && evt_ready;
	assign done_valid = (state_q == S_OUT);
	assign done       = res_q;

	assign now      = TIME_BITS'(evt.timestamp);
	assign layer_ok = {1'b0, evt.layer} < (LAYER_W + 1)'(LAYER_COUNT);
	assign depth_ok = CMP_W'(count_q) == CMP_W'(evt.expected_depth);
	assign tag_ok   = evt.session_tag == TAG_W'(sess_q);
	assign full     = count_q == CNT_W'(STACK_DEPTH);
	assign sess_max = &sess_q;
	assign push     = accept && evt.func == FN_OPEN && active_q && layer_ok && !full;

	assign rd_layer = ram_rdata[FW-1 -: LAYER_W];
	assign rd_start = ram_rdata[2*TIME_BITS-1 -: TIME_BITS];
	assign rd_child = ram_rdata[TIME_BITS-1:0];

	// borrow-out of the subtracts gives the clamp at zero; carry-out of the parent sum saturates it
	assign incl_diff = {1'b0, now_q} - {1'b0, rd_start};
	assign self_diff = {1'b0, incl_q} - {1'b0, child_q};
	assign par_sum   = {1'b0, rd_child} + {1'b0, incl_q};
	assign par_child = par_sum[TIME_BITS] ? '1 : par_sum[TIME_BITS-1:0];

	// top frame read at accept, parent frame read after the pop decision
	assign ram_raddr = (state_q == S_SELF) ? AW'(count_q - CNT_W'(2))
	                                       : AW'(count_q - CNT_W'(1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(count_q);
		ram_wdata = {evt.layer, now, {TIME_BITS{1'b0}}};
		if (push) begin
			ram_we = 1'b1;
		end else if (state_q == S_PAR) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(count_q - CNT_W'(1));
			ram_wdata = {rd_layer, rd_start, par_child};
		end
	end

	// event decode: result and session/stack updates for the transaction at the input
	always_comb begin
		acc_res    = '0;
		acc_state  = S_OUT;
		acc_count  = count_q;
		acc_active = active_q;
		acc_failed = failed_q;
		acc_sess   = sess_q;
		unique case (evt.func)
			FN_OPEN: begin
				if (!active_q) begin
					acc_res.status = STS_IGNORED;
				end else if (!layer_ok) begin
					acc_res.status = STS_BAD_LAYER;
				end else if (full) begin
					acc_failed     = 1'b1;
					acc_res.status = STS_OVERFLOW;
				end else begin
					acc_count           = count_q + CNT_W'(1);
					acc_res.out_layer   = evt.layer;
					acc_res.out_depth   = DEPTH_W'(count_q + CNT_W'(1));
					acc_res.out_session = TAG_W'(sess_q);
				end
			end
			FN_CLOSE: begin
				if (!evt.scope_armed || !active_q || !tag_ok) begin
					acc_res.status = STS_IGNORED;
				end else if (count_q == '0 || !depth_ok) begin
					acc_failed     = 1'b1;
					acc_res.status = STS_MISMATCH;
				end else begin
					acc_state = S_TOP;
				end
			end
			FN_START: begin
				if (active_q) begin
					acc_res.status = STS_ACTIVE;
				end else if (sess_max) begin
					acc_res.status = STS_EXHAUSTED;
				end else begin
					acc_sess            = sess_q + SESSION_BITS'(1);
					acc_active          = 1'b1;
					acc_failed          = 1'b0;
					acc_count           = '0;
					acc_res.out_session = TAG_W'(sess_q + SESSION_BITS'(1));
				end
			end
			FN_STOP: begin
				if (!active_q) begin
					acc_res.status = STS_NOT_ACTIVE;
				end else if (!failed_q && count_q != '0) begin
					acc_res.status = STS_UNCLOSED;
				end else begin
					acc_res.status = failed_q ? STS_REC_FAIL : STS_OK;
					acc_active     = 1'b0;
					acc_failed     = 1'b0;
					acc_count      = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			active_q <= 1'b0;
			failed_q <= 1'b0;
			sess_q   <= '0;
			now_q    <= '0;
			layer_q  <= '0;
			incl_q   <= '0;
			child_q  <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						now_q    <= now;
						layer_q  <= evt.layer;
						res_q    <= acc_res;
						state_q  <= acc_state;
						count_q  <= acc_count;
						active_q <= acc_active;
						failed_q <= acc_failed;
						sess_q   <= acc_sess;
					end
				end
				S_TOP: begin
					// top frame data is valid now
					if (rd_layer != layer_q) begin
						failed_q     <= 1'b1;
						res_q.status <= STS_MISMATCH;
						state_q      <= S_OUT;
					end else begin
						incl_q          <= incl_diff[TIME_BITS] ? '0 : incl_diff[TIME_BITS-1:0];
						child_q         <= rd_child;
						res_q.out_layer <= rd_layer;
						state_q         <= S_SELF;
					end
				end
				S_SELF: begin
					res_q.status       <= STS_OK;
					res_q.sample_valid <= 1'b1;
					res_q.inclusive_ns <= TS_W'(incl_q);
					res_q.self_ns      <= self_diff[TIME_BITS] ? '0
					                                           : TS_W'(self_diff[TIME_BITS-1:0]);
					count_q            <= count_q - CNT_W'(1);
					state_q            <= (count_q > CNT_W'(1)) ? S_PAR : S_OUT;
				end
				S_PAR: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count above depth");

	a_idle_stack: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (count_q == '0 && !failed_q))
		else $error("stack or failure flag set outside a session");

	a_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE || state_q == S_PAR))
		else $error("frame write outside push or parent update");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !evt_ready)
		else $error("new transaction taken while one is in flight");

endmodule

`default_nettype wire

>>> tb/nrstp_self_time_checker.sv
// nrstp_self_time_checker: watches the event and result channels of the profiler,
// keeps its own copy of the range stack and session state, and compares every result
// depends on nrstp_pkg
`default_nettype none

module nrstp_self_time_checker
	import nrstp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic evt_valid,
	input  wire logic evt_ready,
	input  wire evt_t evt,
	input  wire logic res_valid,
	input  wire logic res_ready,
	input  wire res_t res,
	output int unsigned outstanding,
	output int unsigned failures
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TS_W-1:0] TIME_TOP = {TS_W{1'b1}};
	localparam logic [SESSION_BITS_DEF-1:0] SESS_TOP = {SESSION_BITS_DEF{1'b1}};

	logic [LAYER_W-1:0]          frm_layer [STACK_DEPTH_DEF];
	logic [TS_W-1:0]             frm_start [STACK_DEPTH_DEF];
	logic [TS_W-1:0]             frm_child [STACK_DEPTH_DEF];
	int unsigned                 depth;
	bit                          in_session;
	bit                          broken;
	logic [SESSION_BITS_DEF-1:0] sess_num;
	res_t                        due_results [$];

	// one event against the stack, returns the result it should produce
	function automatic res_t profile_event(evt_t e);
		res_t r;
		logic [TS_W-1:0] span;
		logic [TS_W:0] sum;
		int unsigned top;
		r = '0;
		r.status = STS_OK;
		case (e.func)
		FN_OPEN: begin
			if (!in_session) r.status = STS_IGNORED;
			else if (e.layer >= LAYER_COUNT_DEF) r.status = STS_BAD_LAYER;
			else if (depth >= STACK_DEPTH_DEF) begin
				broken = 1'b1;
				r.status = STS_OVERFLOW;
			end else begin
				frm_layer[depth] = e.layer;
				frm_start[depth] = e.timestamp;
				frm_child[depth] = '0;
				depth++;
				r.out_layer = e.layer;
				r.out_depth = DEPTH_W'(depth);
				r.out_session = TAG_W'(sess_num);
			end
		end
		FN_CLOSE: begin
			if (!e.scope_armed || !in_session || e.session_tag != TAG_W'(sess_num))
				r.status = STS_IGNORED;
			else if (depth == 0 || depth != e.expected_depth ||
					frm_layer[depth-1] != e.layer) begin
				broken = 1'b1;
				r.status = STS_MISMATCH;
			end else begin
				top = depth - 1;
				span = (e.timestamp > frm_start[top]) ? e.timestamp - frm_start[top] : '0;
				r.inclusive_ns = span;
				r.self_ns = (span >= frm_child[top]) ? span - frm_child[top] : '0;
				depth = top;
				// parent child time saturates at the top of the time range
				if (top > 0) begin
					sum = {1'b0, frm_child[top-1]} + {1'b0, span};
					frm_child[top-1] = sum[TS_W] ? TIME_TOP : sum[TS_W-1:0];
				end
				r.sample_valid = 1'b1;
				r.out_layer = frm_layer[top];
			end
		end
		FN_START: begin
			if (in_session) r.status = STS_ACTIVE;
			else if (sess_num == SESS_TOP) r.status = STS_EXHAUSTED;
			else begin
				sess_num++;
				in_session = 1'b1;
				broken = 1'b0;
				depth = 0;
				r.out_session = TAG_W'(sess_num);
			end
		end
		FN_STOP: begin
			if (!in_session) r.status = STS_NOT_ACTIVE;
			else if (!broken && depth != 0) r.status = STS_UNCLOSED;
			else begin
				r.status = broken ? STS_REC_FAIL : STS_OK;
				in_session = 1'b0;
				broken = 1'b0;
				depth = 0;
			end
		end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [TS_W-1:0] want, logic [TS_W-1:0] got,
			inout bit bad);
		if (got !== want) begin
			bad = 1'b1;
			$display("%0t res.%s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		bit bad;
		if (!arst_n) begin
			depth = 0;
			in_session = 1'b0;
			broken = 1'b0;
			sess_num = '0;
			failures = 0;
			due_results.delete();
			outstanding <= 0;
		end else begin
			// results first: a result at this edge belongs to an earlier event
			if (res_valid && res_ready) begin
				if (due_results.size() == 0) begin
					failures++;
					$display("%0t res with nothing expected: expected none, actual %h",
						$time, res);
				end else begin
					want = due_results.pop_front();
					bad = 1'b0;
					check_field("status", want.status, res.status, bad);
					check_field("sample_valid", want.sample_valid, res.sample_valid, bad);
					check_field("out_layer", want.out_layer, res.out_layer, bad);
					check_field("out_depth", want.out_depth, res.out_depth, bad);
					check_field("out_session", want.out_session, res.out_session, bad);
					check_field("inclusive_ns", want.inclusive_ns, res.inclusive_ns, bad);
					check_field("self_ns", want.self_ns, res.self_ns, bad);
					if (bad) failures++;
				end
			end
			if (evt_valid && evt_ready)
				due_results.insert(due_results.size(), profile_event(evt));
			outstanding <= due_results.size();
		end
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench: stimulus and verdict for nested_range_self_time_profiler_unit
// depends on nrstp_pkg, the profiler rtl and nrstp_self_time_checker
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nrstp_pkg::*;

	// a run stays well under the limit even with the longest gaps and stalls
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned RANDOM_ITEMS = 390;
	localparam int unsigned LEAD_ITEMS = 60;
	localparam logic [TAG_W-1:0] LAST_SESSION = {TAG_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_ready;
	evt_t evt = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	int unsigned outstanding;
	int unsigned failures;

	// calm: both sides run without idle cycles
	bit calm = 1'b0;
	int unsigned cycles = 0;
	int unsigned sent = 0;

	// what a caller would know: its clock, its session and the ranges it has open
	logic [TS_W-1:0]    now_ns = '0;
	int unsigned        sess_id = 0;
	bit                 live = 1'b0;
	bit                 spoiled = 1'b0;
	logic [LAYER_W-1:0] open_layers [$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	nested_range_self_time_profiler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	nrstp_self_time_checker range_check (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.outstanding(outstanding),
		.failures(failures)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: a random stall before each transaction, none while calm
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
		end
	end

	// caller clock: mostly small steps, now and then a big jump or a random value,
	// so inclusive times sometimes go negative and get clamped
	function automatic logic [TS_W-1:0] tick();
		case ($urandom_range(0, 19))
		0: now_ns = TS_W'({$urandom, $urandom});
		1, 2: now_ns += TS_W'($urandom);
		default: now_ns += TS_W'($urandom_range(0, 2000));
		endcase
		return now_ns;
	endfunction

	function automatic evt_t make_evt(logic [FUNC_W-1:0] f, logic [LAYER_W-1:0] l,
			logic [TS_W-1:0] ts, logic [DEPTH_W-1:0] d, logic [TAG_W-1:0] tag, logic armed);
		evt_t e;
		e.func = f;
		e.layer = l;
		e.timestamp = ts;
		e.expected_depth = d;
		e.session_tag = tag;
		e.scope_armed = armed;
		return e;
	endfunction

	// one event transaction; entered and left at a rising edge, valid held until taken
	task automatic send(evt_t e);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (!evt_ready);
		sent++;
	endtask

	// fields an event kind does not use carry random values
	task automatic do_open(logic [LAYER_W-1:0] l, logic [TS_W-1:0] ts);
		send(make_evt(FN_OPEN, l, ts, DEPTH_W'($urandom_range(0, 16)), TAG_W'($urandom),
			1'($urandom)));
		if (live && l < LAYER_COUNT_DEF) begin
			if (open_layers.size() < STACK_DEPTH_DEF)
				open_layers.insert(open_layers.size(), l);
			else spoiled = 1'b1;
		end
	endtask

	task automatic do_close(logic [LAYER_W-1:0] l, logic [DEPTH_W-1:0] d,
			logic [TAG_W-1:0] tag, logic armed, logic [TS_W-1:0] ts);
		send(make_evt(FN_CLOSE, l, ts, d, tag, armed));
		if (armed && live && tag == TAG_W'(sess_id)) begin
			if (open_layers.size() != 0 && d == open_layers.size() && l == open_layers[$])
				open_layers.delete(open_layers.size() - 1);
			else spoiled = 1'b1;
		end
	endtask

	// well-formed close of the innermost open range
	task automatic close_top(logic [TS_W-1:0] ts);
		do_close(open_layers[$], DEPTH_W'(open_layers.size()), TAG_W'(sess_id), 1'b1, ts);
	endtask

	task automatic do_start(logic [TS_W-1:0] ts);
		send(make_evt(FN_START, LAYER_W'($urandom), ts, DEPTH_W'($urandom_range(0, 16)),
			TAG_W'($urandom), 1'($urandom)));
		if (!live && sess_id < LAST_SESSION) begin
			sess_id++;
			live = 1'b1;
			spoiled = 1'b0;
			open_layers.delete();
		end
	endtask

	task automatic do_stop(logic [TS_W-1:0] ts);
		send(make_evt(FN_STOP, LAYER_W'($urandom), ts, DEPTH_W'($urandom_range(0, 16)),
			TAG_W'($urandom), 1'($urandom)));
		if (live && (spoiled || open_layers.size() == 0)) begin
			live = 1'b0;
			spoiled = 1'b0;
			open_layers.delete();
		end
	endtask

	initial begin
		int unsigned steps;
		int unsigned bias;
		int unsigned pick;
		logic [LAYER_W-1:0] l;
		logic [DEPTH_W-1:0] d;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every event kind outside and inside a session
		do_open(4'd0, '0);                          // open with no session
		do_close(4'd0, 5'd1, 16'd0, 1'b1, '0);      // close with no session
		do_stop('0);                                // stop with no session
		do_start('0);                               // session 1
		do_start('0);                               // start while active
		do_open(4'd15, '0);                         // layer out of range
		do_open(4'd0, '0);                          // parent at time zero
		do_open(4'd11, '0);                         // highest valid layer
		close_top('1);                              // full-range inclusive time
		do_open(4'd5, '0);
		close_top('1);                              // parent child time saturates
		do_stop('1);                                // stop with a range open
		close_top(48'd5);                           // self time floored at zero
		do_open(4'd3, 48'd100);
		do_close(4'd3, 5'd1, 16'd0, 1'b1, 48'd120); // stale session tag
		do_close(4'd3, 5'd1, 16'd1, 1'b0, 48'd120); // opened outside a session
		close_top(48'd50);                          // end before start clamps to zero
		do_close(4'd0, 5'd0, 16'd1, 1'b1, 48'd60);  // close on an empty stack
		do_stop(48'd70);                            // recording failed
		do_start(48'd80);                           // session 2
		do_open(4'd2, 48'd90);
		do_close(4'd7, 5'd1, 16'd2, 1'b1, 48'd95);  // layer mismatch
		do_close(4'd2, 5'd3, 16'd2, 1'b1, 48'd96);  // depth mismatch
		do_stop(48'd97);                            // failed session ends with a range open

		// fill the stack, push one past it, then unwind it completely
		do_start(tick());
		repeat (STACK_DEPTH_DEF + 1)
			do_open(LAYER_W'($urandom_range(0, LAYER_COUNT_DEF - 1)), tick());
		while (open_layers.size() != 0) close_top(tick());
		do_stop(tick());

		// random sessions: mostly well-formed nesting with random times, some noise
		while (sent < LEAD_ITEMS + RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				// stray event before the next session start
				case ($urandom_range(0, 2))
				0: do_open(LAYER_W'($urandom), tick());
				1: do_close(LAYER_W'($urandom), DEPTH_W'($urandom_range(0, 16)),
					TAG_W'(sess_id), 1'b1, tick());
				default: do_stop(tick());
				endcase
			end
			do_start(tick());
			// one session in five leans to opens so that it may grow deep enough to hit the stack limit
			bias = ($urandom_range(0, 4) == 0) ? 70 : 45;
			steps = $urandom_range(4, 40);
			repeat (steps) begin
				pick = $urandom_range(0, 99);
				l = (open_layers.size() != 0) ? open_layers[$] : LAYER_W'($urandom);
				d = DEPTH_W'(open_layers.size());
				if (pick < bias || (pick < 92 && open_layers.size() == 0)) begin
					if ($urandom_range(0, 9) == 0)
						l = LAYER_W'($urandom_range(LAYER_COUNT_DEF, 15));
					else
						l = LAYER_W'($urandom_range(0, LAYER_COUNT_DEF - 1));
					do_open(l, tick());
				end else if (pick < 92) begin
					close_top(tick());
				end else begin
					case ($urandom_range(0, 5))
					0: do_close(LAYER_W'($urandom), d, TAG_W'(sess_id), 1'b1, tick());
					1: do_close(l, DEPTH_W'($urandom_range(0, 16)), TAG_W'(sess_id), 1'b1,
						tick());
					2: do_close(l, d, TAG_W'($urandom), 1'b1, tick());
					3: do_close(l, d, TAG_W'(sess_id), 1'b0, tick());
					4: do_stop(tick());
					default: do_start(tick());
					endcase
				end
			end
			// most sessions unwind cleanly, the rest stop with any ranges still open
			if ($urandom_range(0, 4) != 0)
				while (live && open_layers.size() != 0) close_top(tick());
			do_stop(tick());
		end

		// close out whatever session is still open, back to back
		calm = 1'b1;
		while (live) begin
			while (open_layers.size() != 0) close_top(tick());
			do_stop(tick());
		end

		// drain, then give the block time to show any stray result
		evt_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
